FILE: src/u8dc_pkg.sv
// ----------------------------------------------------------------------------
// u8dc_pkg
// Shared types, constants and the code point classifier of the UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8dc_pkg;

	localparam int unsigned U8DC_QUEUE_DEPTH = 4;

	typedef logic [15:0] cp_t;
	typedef logic [2:0]  cls_t;

	localparam cls_t CLASS_ASCII       = 3'd0;
	localparam cls_t CLASS_FW_PUNCT    = 3'd1;
	localparam cls_t CLASS_FW_CHAR     = 3'd2;
	localparam cls_t CLASS_CJK         = 3'd3;
	localparam cls_t CLASS_UNSUPPORTED = 3'd4;

	localparam cp_t ASCII_LO    = 16'h0020;
	localparam cp_t ASCII_HI    = 16'h007E;
	localparam cp_t FW_PUNCT_LO = 16'h3000;
	localparam cp_t FW_PUNCT_HI = 16'h303F;
	localparam cp_t FW_CHAR_LO  = 16'hFF00;
	localparam cp_t FW_CHAR_HI  = 16'hFFEF;
	localparam cp_t CJK_LO      = 16'h4E00;
	localparam cp_t CJK_HI      = 16'h9FA5;

	typedef struct packed {
		logic vld;
		cp_t  cp;
	} cp_word_t;

	function automatic cls_t classify(input cp_t cp);
		cls_t c;
		if (cp >= ASCII_LO && cp <= ASCII_HI) begin
			c = CLASS_ASCII;
		end else if (cp >= FW_PUNCT_LO && cp <= FW_PUNCT_HI) begin
			c = CLASS_FW_PUNCT;
		end else if (cp >= FW_CHAR_LO && cp <= FW_CHAR_HI) begin
			c = CLASS_FW_CHAR;
		end else if (cp >= CJK_LO && cp <= CJK_HI) begin
			c = CLASS_CJK;
		end else begin
			c = CLASS_UNSUPPORTED;
		end
		return c;
	endfunction

endpackage

FILE: src/u8dc_front.sv
// ----------------------------------------------------------------------------
// u8dc_front
// Byte assembler: tracks open sequences and emits completed code points.
// ----------------------------------------------------------------------------
module u8dc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic [7:0]        data_byte,
	output u8dc_pkg::cp_word_t wr
);
	import u8dc_pkg::*;

	logic [1:0] pending_q;
	cp_t        partial_q;
	logic [1:0] pending_d;
	cp_t        partial_d;
	cp_t        acc_cp;

	assign acc_cp = cp_t'({partial_q[9:0], data_byte[5:0]});

	always_comb begin
		pending_d = pending_q;
		partial_d = partial_q;
		wr.vld    = 1'b0;
		wr.cp     = acc_cp;
		if (acc) begin
			if (pending_q != 2'd0) begin
				pending_d = pending_q - 2'd1;
				if (pending_q == 2'd1) begin
					partial_d = '0;
					wr.vld    = 1'b1;
				end else begin
					partial_d = acc_cp;
				end
			end else if (data_byte[7] == 1'b0) begin
				wr.vld = 1'b1;
				wr.cp  = {8'h00, data_byte};
			end else if (data_byte[7:5] == 3'b110) begin
				partial_d = {11'd0, data_byte[4:0]};
				pending_d = 2'd1;
			end else if (data_byte[7:4] == 4'b1110) begin
				partial_d = {12'd0, data_byte[3:0]};
				pending_d = 2'd2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			partial_q <= '0;
		end else begin
			pending_q <= pending_d;
			partial_q <= partial_d;
		end
	end

	a_pending_range: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3) else $error("pending count out of range");
	a_no_emit_midseq: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == 2'd2) |-> !wr.vld) else $error("word emitted mid sequence");
	a_partial_clear: assert property (@(posedge clk) disable iff (!arst_n)
		wr.vld |=> (partial_q == '0)) else $error("partial not cleared");

endmodule

FILE: src/u8dc_fifo.sv
// ----------------------------------------------------------------------------
// u8dc_fifo
// Short queue of code points between the assembler and the classifier.
// ----------------------------------------------------------------------------
module u8dc_fifo #(
	parameter int unsigned DEPTH = u8dc_pkg::U8DC_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  u8dc_pkg::cp_word_t wr,
	input  logic               rd,
	output u8dc_pkg::cp_t      rd_cp,
	output logic               nonempty,
	output logic               full
);
	import u8dc_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULLCNT = CW'(DEPTH);

	cp_t           mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full     = (cnt_q == FULLCNT);
	assign nonempty = (cnt_q != '0);
	assign do_wr    = wr.vld && !full;
	assign do_rd    = rd && nonempty;
	assign rd_cp    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr.cp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + AW'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULLCNT) else $error("queue count overflow");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.vld && full)) else $error("word dropped on full queue");
	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("queue count not advanced");

endmodule

FILE: src/u8dc_back.sv
// ----------------------------------------------------------------------------
// u8dc_back
// Classifier and output register: labels each code point and holds the word.
// ----------------------------------------------------------------------------
module u8dc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_nonempty,
	input  u8dc_pkg::cp_t  q_cp,
	output logic           q_rd,
	input  logic           pop,
	output logic           empty,
	output logic [15:0]    code_point,
	output logic [2:0]     char_class,
	output logic           is_supported
);
	import u8dc_pkg::*;

	logic vld_q;
	cp_t  cp_q;
	cls_t cls_q;
	logic sup_q;
	cls_t cls_d;

	assign cls_d = classify(q_cp);
	assign q_rd  = q_nonempty && (!vld_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!vld_q || pop) begin
			vld_q <= q_nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cp_q  <= q_cp;
			cls_q <= cls_d;
			sup_q <= (cls_d != CLASS_UNSUPPORTED);
		end
	end

	assign empty        = !vld_q;
	assign code_point   = cp_q;
	assign char_class   = cls_q;
	assign is_supported = sup_q;

	a_sup_match: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> (sup_q == (cls_q != CLASS_UNSUPPORTED))) else $error("flag mismatch");
	a_cls_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> (cls_q <= CLASS_UNSUPPORTED)) else $error("class out of range");
	a_load_ok: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |=> vld_q) else $error("loaded word lost");

endmodule

FILE: src/utf8_decode_classify.sv
// ----------------------------------------------------------------------------
// utf8_decode_classify
// UTF-8 decoder for one to three byte forms with code point classification.
// ----------------------------------------------------------------------------
// channel   direction  handshake        payload
// bytes     in         push / full      data_byte
// results   out        empty / pop      code_point, char_class, is_supported
//
// One byte is taken per cycle while full is low; full rises only when the
// code point queue is full. A completed code point passes through the queue
// and the output register. Reset clears the open sequence, the queue and
// the output valid flag. Both sides stall independently through the queue.
// ----------------------------------------------------------------------------
module utf8_decode_classify #(
	parameter int unsigned QUEUE_DEPTH = u8dc_pkg::U8DC_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] code_point,
	output logic [2:0]  char_class,
	output logic        is_supported
);
	import u8dc_pkg::*;

	cp_word_t wr;
	cp_t      q_cp;
	logic     q_rd;
	logic     q_nonempty;
	logic     acc;

	assign acc = push && !full;

	u8dc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.data_byte (data_byte),
		.wr        (wr)
	);

	u8dc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd       (q_rd),
		.rd_cp    (q_cp),
		.nonempty (q_nonempty),
		.full     (full)
	);

	u8dc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.q_cp         (q_cp),
		.q_rd         (q_rd),
		.pop          (pop),
		.empty        (empty),
		.code_point   (code_point),
		.char_class   (char_class),
		.is_supported (is_supported)
	);

endmodule
